// ===== rtl/dual_channel_moving_average_alarm_top_macros.svh =====
// Assertion macros shared by the moving-average alarm RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_ALARM_TOP_MACROS_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_ALARM_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCMAA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcmaa assertion failed");

// Next-cycle implication, disabled during reset.
`define DCMAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcmaa assertion failed");

`endif

// ===== rtl/dcmaa_pkg.sv =====
// Shared types and constants for the dual-channel moving-average alarm.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package dcmaa_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int DIV_BITS          = 5;   // quotient bits resolved per divide cycle
   localparam int REQ_TDATA_W       = 32;
   localparam int RSP_TDATA_W       = 48;
   localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd300;
   localparam logic [SAMPLE_W-1:0]        ALARM_COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;      // capture the samples, read the oldest ring entry
      logic update;    // update running sums, write the ring, start divide
      logic div_step;  // advance the divider by one step
      logic finish;    // sign-fix, compare, count, load the result register
   } cmd_type;

   typedef struct packed {
      logic div_last;  // divider is on its final step
   } status_type;

endpackage

// ===== rtl/dcmaa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dcmaa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 5
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dcmaa_datapath.sv =====
// Datapath: shared sample ring, running sums, radix-32 divider, alarm logic, result register.
// Depends on dcmaa_pkg, dcmaa_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_channel_moving_average_alarm_top_macros.svh"

module dcmaa_datapath #(
   parameter int WINDOW = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dcmaa_pkg::cmd_type          cmd,
   output dcmaa_pkg::status_type       status,
   input  logic signed [15:0]          sample_temperature,
   input  logic [15:0]                 sample_humidity,
   input  logic                        csr_wen,
   input  logic [15:0]                 csr_wdata,
   output logic signed [15:0]          avg_temperature,
   output logic [15:0]                 avg_humidity,
   output logic                        over_temperature,
   output logic [15:0]                 alarm_total
);

   import dcmaa_pkg::*;

   localparam int PTR_W     = $clog2(WINDOW);
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
   localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int QUO_W     = DIV_STEPS * DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [PTR_W-1:0]  LAST_POS  = PTR_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   // One divider step: DIV_BITS restoring iterations on a narrow remainder.
   function automatic logic [CNT_W+QUO_W-1:0] div_step_f(
      input logic [CNT_W-1:0] rem,
      input logic [QUO_W-1:0] quo,
      input logic [CNT_W-1:0] den
   );
      logic [CNT_W:0]   trial;
      logic [CNT_W-1:0] r;
      logic [QUO_W-1:0] q;
      r = rem;
      q = quo;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial = {r, q[QUO_W-1]};
         q = {q[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            trial = trial - {1'b0, den};
            q[0] = 1'b1;
         end
         r = trial[CNT_W-1:0];
      end
      return {r, q};
   endfunction

   // Registers
   logic signed [SAMPLE_W-1:0] samp_t_ff;
   logic [SAMPLE_W-1:0]        samp_h_ff;
   logic [PTR_W-1:0]           wr_pos_ff, wr_pos_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic signed [SUM_W-1:0]    sum_t_ff, sum_t_in;
   logic [SUM_W-1:0]           sum_h_ff, sum_h_in;
   logic signed [SAMPLE_W-1:0] thresh_ff;
   logic [SAMPLE_W-1:0]        alarm_ff, alarm_in;
   logic [CNT_W-1:0]           den_ff;
   logic [QUO_W-1:0]           quo_t_ff, quo_h_ff;
   logic [CNT_W-1:0]           rem_t_ff, rem_h_ff;
   logic                       neg_ff;
   logic [STEP_W-1:0]          step_ff;
   logic signed [SAMPLE_W-1:0] avg_t_ff;
   logic [SAMPLE_W-1:0]        avg_h_ff;
   logic                       over_ff;
   logic [SAMPLE_W-1:0]        alarm_out_ff;

   logic [2*SAMPLE_W-1:0]      ram_rd_data;
   logic signed [SAMPLE_W-1:0] old_t;
   logic [SAMPLE_W-1:0]        old_h;
   logic                       full;
   logic [SUM_W-1:0]           abs_t;
   logic [CNT_W-1:0]           den_in;
   logic [CNT_W+QUO_W-1:0]     step_t, step_h;
   logic signed [SAMPLE_W-1:0] avg_t_in;
   logic                       over_in;

   dcmaa_ram #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (wr_pos_ff),
      .wr_data ({samp_h_ff, samp_t_ff}),
      .rd_en   (cmd.load),
      .rd_addr (wr_pos_ff),
      .rd_data (ram_rd_data)
   );

   assign old_t = ram_rd_data[SAMPLE_W-1:0];
   assign old_h = ram_rd_data[2*SAMPLE_W-1:SAMPLE_W];
   assign full  = (fill_ff == FULL_CNT);

   always_comb begin
      // drop the oldest entry only once the ring has wrapped
      sum_t_in = sum_t_ff + SUM_W'(samp_t_ff);
      sum_h_in = sum_h_ff + SUM_W'(samp_h_ff);
      if (full) begin
         sum_t_in = sum_t_in - SUM_W'(old_t);
         sum_h_in = sum_h_in - SUM_W'(old_h);
      end
      abs_t     = sum_t_in[SUM_W-1] ? SUM_W'(-sum_t_in) : SUM_W'(sum_t_in);
      wr_pos_in = (wr_pos_ff == LAST_POS) ? '0 : wr_pos_ff + 1'b1;
      fill_in   = full ? fill_ff : fill_ff + 1'b1;
      den_in    = fill_in;
   end

   assign step_t = div_step_f(rem_t_ff, quo_t_ff, den_ff);
   assign step_h = div_step_f(rem_h_ff, quo_h_ff, den_ff);

   always_comb begin
      avg_t_in = neg_ff ? -$signed(quo_t_ff[SAMPLE_W-1:0]) : $signed(quo_t_ff[SAMPLE_W-1:0]);
      over_in  = (avg_t_in > thresh_ff);
      alarm_in = alarm_ff;
      if (over_in && (alarm_ff != ALARM_COUNT_MAX)) begin
         alarm_in = alarm_ff + 1'b1;
      end
   end

   assign status.div_last = (step_ff == LAST_STEP);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         fill_ff   <= '0;
         sum_t_ff  <= '0;
         sum_h_ff  <= '0;
         thresh_ff <= THRESHOLD_RESET;
         alarm_ff  <= '0;
         step_ff   <= '0;
      end else begin
         if (csr_wen) begin
            thresh_ff <= csr_wdata;
         end
         if (cmd.update) begin
            wr_pos_ff <= wr_pos_in;
            fill_ff   <= fill_in;
            sum_t_ff  <= sum_t_in;
            sum_h_ff  <= sum_h_in;
            step_ff   <= '0;
         end else if (cmd.div_step) begin
            step_ff <= step_ff + 1'b1;
         end
         if (cmd.finish) begin
            alarm_ff <= alarm_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         samp_t_ff <= sample_temperature;
         samp_h_ff <= sample_humidity;
      end
      if (cmd.update) begin
         den_ff   <= den_in;
         neg_ff   <= sum_t_in[SUM_W-1];
         quo_t_ff <= QUO_W'(abs_t);
         quo_h_ff <= QUO_W'(sum_h_in);
         rem_t_ff <= '0;
         rem_h_ff <= '0;
      end else if (cmd.div_step) begin
         {rem_t_ff, quo_t_ff} <= step_t;
         {rem_h_ff, quo_h_ff} <= step_h;
      end
      if (cmd.finish) begin
         avg_t_ff     <= avg_t_in;
         avg_h_ff     <= quo_h_ff[SAMPLE_W-1:0];
         over_ff      <= over_in;
         alarm_out_ff <= alarm_in;
      end
   end

   assign avg_temperature  = avg_t_ff;
   assign avg_humidity     = avg_h_ff;
   assign over_temperature = over_ff;
   assign alarm_total      = alarm_out_ff;

   `DCMAA_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FULL_CNT)
   `DCMAA_ASSERT_NOW(a_pos_bound, clock, reset, 1'b1, wr_pos_ff <= LAST_POS)
   `DCMAA_ASSERT_NEXT(a_alarm_monotonic, clock, reset, 1'b1, alarm_ff >= $past(alarm_ff))

endmodule

// ===== rtl/dcmaa_controller.sv =====
// Controller: sequences load, update, divide and finish; owns the stream handshakes.
// Depends on dcmaa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_channel_moving_average_alarm_top_macros.svh"

module dcmaa_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dcmaa_pkg::cmd_type     cmd,
   input  dcmaa_pkg::status_type  status
);

   import dcmaa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;

   `DCMAA_ASSERT_NOW(a_finish_slot_free, clock, reset, cmd.finish, !rsp_valid_ff || rsp_tready)
   `DCMAA_ASSERT_NEXT(a_accept_to_update, clock, reset, req_tvalid && req_tready, state_ff == ST_UPDATE)
   `DCMAA_ASSERT_NEXT(a_finish_sets_valid, clock, reset, cmd.finish, rsp_valid_ff)

endmodule

// ===== rtl/dual_channel_moving_average_alarm_top.sv =====
// Top level of the dual-channel moving-average alarm.
// Depends on dcmaa_pkg, dcmaa_controller and dcmaa_datapath.
//
// Usage:
//   req channel: one transaction carries a signed temperature and an unsigned
//   humidity sample. rsp channel: one transaction per request with both
//   channel means, the over-temperature flag and the saturating alarm count.
//   csr port: csr_wen writes the signed alarm threshold (reset value 300);
//   write it only while no request is in flight.
// Sequence:
//   An accepted item passes through the update state, in which the running
//   sums are updated, the divide state and the finish state, which loads the
//   result register. The divider resolves five quotient bits per cycle for
//   both channels. The accepting cycle is a state of its own, and a new
//   request is taken only once the block is back in idle after the finish state.
// Reset: synchronous; clears the ring position, fill count, running sums and
//   alarm count, and loads the threshold with 300. Ring contents stay as is.
// Stall: a finished result waits in the output register; the next request is
//   still accepted and processed, and holds in its last step until the output
//   register is taken.
`timescale 1ns / 1ps

module dual_channel_moving_average_alarm_top #(
   parameter int WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [15:0] sample_temperature, [31:16] sample_humidity
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // rsp_tdata: [15:0] avg_temperature, [31:16] avg_humidity, [47:32] alarm_total
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // rsp_tuser: [0] over_temperature
   output logic        rsp_tuser,
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   import dcmaa_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic signed [15:0] avg_t;
   logic [15:0]        avg_h;
   logic [15:0]        alarm_cnt;

   dcmaa_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dcmaa_datapath #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .sample_temperature (req_tdata[15:0]),
      .sample_humidity    (req_tdata[31:16]),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata),
      .avg_temperature    (avg_t),
      .avg_humidity       (avg_h),
      .over_temperature   (rsp_tuser),
      .alarm_total        (alarm_cnt)
   );

   assign rsp_tdata = {alarm_cnt, avg_h, avg_t};

endmodule
